/* design/srfp_pkg.sv */
// Package for the source rank fetch planner: sizes, score constants, register
// and status codes, and the command and status bundles between controller and datapath.
// No dependencies.
package srfp_pkg;

  localparam int MAX_SOURCES = 32;
  localparam int IDX_W       = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CNT_W       = $clog2(MAX_SOURCES + 1);

  localparam int CFG_W    = 7;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int REL_W    = 16;
  localparam int LAT_W    = 24;
  localparam int THR_W    = 40;
  localparam int SHARD_W  = 8;
  localparam int RANK_W   = 6;
  localparam int SCORE_W  = 34;
  localparam int QUO_W    = 20;
  localparam int RELC_W   = 14;
  localparam int TCAP_W   = 17;
  localparam int PLAT_W   = 30;
  localparam int STEP_W   = 5;
  localparam int ENTRY_W  = SCORE_W + SHARD_W;

  // throughput / 1e6 as (throughput >> 6) * ceil(2^45 / 15625) >> 45,
  // exact for every shifted value below 2^31
  localparam int THR_SHIFT  = 6;
  localparam int THR_SH_W   = 31;
  localparam int THR_RSH    = 45;
  localparam int THR_PROD_W = 63;

  localparam logic [QUO_W-1:0]  LAT_DIVIDEND = 20'd1000000;
  localparam logic [31:0]       THR_RECIP    = 32'd2251799814;
  localparam logic [RELC_W-1:0] REL_CAP      = 14'd10000;
  localparam logic [TCAP_W-1:0] THR_CAP      = 17'd100000;
  localparam logic [THR_W-1:0]  THR_CLAMP_AT = 40'd100001000000;
  localparam logic [QUO_W-1:0]  SCALE_REL    = 20'd1000000;
  localparam logic [9:0]        SCALE_LAT    = 10'd1000;
  localparam logic [STEP_W-1:0] STEP_LAST    = 5'd19;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic {
    REG_REQUIRED = 1'b0,
    REG_HEDGE    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic start;
    logic store;
    logic scan_start;
    logic emit;
    logic emit_err;
    logic clear;
  } srfp_cmd_t;

  typedef struct packed {
    logic score_done;
    logic run_err;
    logic scan_done;
    logic out_free;
    logic last_pos;
  } srfp_st_t;

endpackage

/* design/source_rank_fetch_planner.sv */
// Top level of the source rank fetch planner: configuration registers on the
// APB-style port, controller and datapath. Uses srfp_pkg, srfp_ctrl, srfp_dpath.
//
// Each source record holds the input off from acceptance until its table write: a
// 20-step bit-serial divider forms 1e6/latency while a reciprocal multiply forms
// throughput/1e6, followed by a multiply stage, a sum stage and the table write;
// the next record is taken the cycle after. After the record marked last,
// ranking rescans the stored table through the single read port of the record
// RAM once per rank, and input is taken again after the last beat of the run is
// issued; the result side can stall each beat. An invalid run returns one error
// beat from the check and error states once the result side is free.
// Configuration must be written only while the block is idle; the block itself
// does not enforce this.
module source_rank_fetch_planner (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [srfp_pkg::PADDR_W-1:0]   paddr,
  input  logic [srfp_pkg::PDATA_W-1:0]   pwdata,
  output logic [srfp_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [srfp_pkg::REL_W-1:0]     in_reliab_bp,
  input  logic [srfp_pkg::LAT_W-1:0]     in_latency_ms,
  input  logic [srfp_pkg::THR_W-1:0]     in_xfer_rate,
  input  logic [srfp_pkg::SHARD_W-1:0]   in_shard_id,
  input  logic                           in_last_source,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_status,
  output logic [srfp_pkg::RANK_W-1:0]    out_rank,
  output logic [srfp_pkg::SHARD_W-1:0]   out_ordered_shard,
  output logic [srfp_pkg::CFG_W-1:0]     out_source_total,
  output logic [srfp_pkg::CFG_W-1:0]     out_launch_count,
  output logic                           out_last_result
);
  import srfp_pkg::*;

  logic [CFG_W-1:0] k_r, hedge_r;
  logic             wr_en;
  cfg_reg_t         reg_sel;
  srfp_cmd_t        cmd;
  srfp_st_t         st;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= CFG_W'(1);
      hedge_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_REQUIRED: k_r     <= pwdata[CFG_W-1:0];
        REG_HEDGE:    hedge_r <= pwdata[CFG_W-1:0];
        default:      k_r     <= k_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_REQUIRED: prdata = PDATA_W'(k_r);
      REG_HEDGE:    prdata = PDATA_W'(hedge_r);
      default:      prdata = '0;
    endcase
  end

  srfp_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_source (in_last_source),
    .in_stall       (in_stall),
    .st             (st),
    .cmd            (cmd)
  );

  srfp_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .need_k            (k_r),
    .hedge_k           (hedge_r),
    .in_reliab_bp      (in_reliab_bp),
    .in_latency_ms     (in_latency_ms),
    .in_xfer_rate      (in_xfer_rate),
    .in_shard_id       (in_shard_id),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_rank          (out_rank),
    .out_ordered_shard (out_ordered_shard),
    .out_source_total  (out_source_total),
    .out_launch_count  (out_launch_count),
    .out_last_result   (out_last_result)
  );

endmodule

/* design/srfp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/srfp_score.sv */
// Score unit: bit-serial division of 1e6 by latency, a reciprocal multiply for
// throughput over 1e6, then scaling and summing into the 34-bit source score. Uses srfp_pkg.
module srfp_score (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [srfp_pkg::REL_W-1:0]     rel,
  input  logic [srfp_pkg::LAT_W-1:0]     lat,
  input  logic [srfp_pkg::THR_W-1:0]     thr,
  output logic                           done,
  output logic [srfp_pkg::SCORE_W-1:0]   score
);
  import srfp_pkg::*;

  logic              busy_r, mul_r, sum_r, done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [LAT_W-1:0]  lat_r;
  logic              latz_r, tclamp_r;
  logic [RELC_W-1:0] relc_r;
  logic [LAT_W-1:0]  l_rem_r;
  logic [QUO_W-1:0]  l_q_r;
  logic [THR_SH_W-1:0] thr_sh_r;
  logic [TCAP_W-1:0] t_q_r;
  logic [SCORE_W-1:0] p_rel_r;
  logic [PLAT_W-1:0]  p_lat_r;
  logic [TCAP_W-1:0]  t_fin_r;
  logic [SCORE_W-1:0] score_r;

  logic [LAT_W:0]    l_trial, l_diff;
  logic              l_ge;
  logic [LAT_W-1:0]  l_rem_nxt;
  logic [THR_PROD_W-1:0] t_prod;
  logic [QUO_W-1:0]  lat_term;
  logic [TCAP_W-1:0] thr_term;
  logic [RELC_W-1:0] relc_nxt;

  always_comb begin
    l_trial   = {l_rem_r, l_q_r[QUO_W-1]};
    l_ge      = l_trial >= {1'b0, lat_r};
    l_diff    = l_trial - {1'b0, lat_r};
    l_rem_nxt = l_ge ? l_diff[LAT_W-1:0] : l_trial[LAT_W-1:0];
    t_prod    = THR_PROD_W'(thr_sh_r) * THR_PROD_W'(THR_RECIP);
    lat_term  = latz_r ? LAT_DIVIDEND : l_q_r;
    thr_term  = tclamp_r ? THR_CAP : t_q_r;
    relc_nxt  = (rel > REL_W'(REL_CAP)) ? REL_CAP : rel[RELC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mul_r  <= 1'b0;
      sum_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      mul_r  <= busy_r && (cnt_r == STEP_LAST);
      sum_r  <= mul_r;
      done_r <= sum_r;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lat_r    <= lat;
      latz_r   <= (lat == '0);
      tclamp_r <= (thr >= THR_CLAMP_AT);
      relc_r   <= relc_nxt;
      l_rem_r  <= '0;
      l_q_r    <= LAT_DIVIDEND;
      thr_sh_r <= thr[THR_SHIFT+THR_SH_W-1:THR_SHIFT];
    end else if (busy_r) begin
      l_rem_r <= l_rem_nxt;
      l_q_r   <= {l_q_r[QUO_W-2:0], l_ge};
      t_q_r   <= t_prod[THR_RSH+TCAP_W-1:THR_RSH];
    end
    if (mul_r) begin
      p_rel_r <= SCORE_W'(relc_r) * SCORE_W'(SCALE_REL);
      p_lat_r <= PLAT_W'(lat_term) * PLAT_W'(SCALE_LAT);
      t_fin_r <= thr_term;
    end
    if (sum_r) begin
      score_r <= p_rel_r + SCORE_W'(p_lat_r) + SCORE_W'(t_fin_r);
    end
  end

  assign done  = done_r;
  assign score = score_r;

endmodule

/* design/srfp_dpath.sv */
// Datapath: score unit, record table, taken flags, selection scan and the
// result register. Uses srfp_pkg, srfp_score and srfp_ram.
module srfp_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  srfp_pkg::srfp_cmd_t            cmd,
  output srfp_pkg::srfp_st_t             st,
  input  logic [srfp_pkg::CFG_W-1:0]     need_k,
  input  logic [srfp_pkg::CFG_W-1:0]     hedge_k,
  input  logic [srfp_pkg::REL_W-1:0]     in_reliab_bp,
  input  logic [srfp_pkg::LAT_W-1:0]     in_latency_ms,
  input  logic [srfp_pkg::THR_W-1:0]     in_xfer_rate,
  input  logic [srfp_pkg::SHARD_W-1:0]   in_shard_id,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic                           out_status,
  output logic [srfp_pkg::RANK_W-1:0]    out_rank,
  output logic [srfp_pkg::SHARD_W-1:0]   out_ordered_shard,
  output logic [srfp_pkg::CFG_W-1:0]     out_source_total,
  output logic [srfp_pkg::CFG_W-1:0]     out_launch_count,
  output logic                           out_last_result
);
  import srfp_pkg::*;

  logic                   score_done;
  logic [SCORE_W-1:0]     score;
  logic [SHARD_W-1:0]     shard_r;
  logic [CNT_W-1:0]       count_r;
  logic                   ovf_r;
  logic [MAX_SOURCES-1:0] taken_r;
  logic                   scan_act_r;
  logic [CNT_W-1:0]       scan_i_r;
  logic                   rd_v_r, rd_last_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic                   have_r;
  logic [SCORE_W-1:0]     best_r;
  logic [SHARD_W-1:0]     best_shard_r;
  logic [IDX_W-1:0]       pick_r;
  logic [CNT_W-1:0]       pos_r;
  logic                   ram_we;
  logic [ENTRY_W-1:0]     rdata;
  logic [SCORE_W-1:0]     rd_score;
  logic [SHARD_W-1:0]     rd_shard;
  logic                   better;
  logic [CNT_W-1:0]       scan_i_inc, pos_inc;
  logic [CFG_W:0]         par_sum, n_ext, par_min;

  logic                   out_valid_r, out_status_r, out_last_r;
  logic [RANK_W-1:0]      out_rank_r;
  logic [SHARD_W-1:0]     out_shard_r;
  logic [CFG_W-1:0]       out_total_r, out_par_r;

  srfp_score u_score (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .rel   (in_reliab_bp),
    .lat   (in_latency_ms),
    .thr   (in_xfer_rate),
    .done  (score_done),
    .score (score)
  );

  assign ram_we = cmd.store && (count_r < CNT_W'(MAX_SOURCES));

  srfp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SOURCES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata ({score, shard_r}),
    .raddr (scan_i_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    rd_score   = rdata[ENTRY_W-1:SHARD_W];
    rd_shard   = rdata[SHARD_W-1:0];
    better     = !taken_r[rd_idx_r] && (!have_r || (rd_score > best_r));
    scan_i_inc = scan_i_r + 1'b1;
    pos_inc    = pos_r + 1'b1;
    par_sum    = {1'b0, need_k} + {1'b0, hedge_k};
    n_ext      = (CFG_W + 1)'(count_r);
    par_min    = (par_sum < n_ext) ? par_sum : n_ext;
  end

  always_comb begin
    st.score_done = score_done;
    st.run_err    = ovf_r || (need_k == '0) ||
                    (need_k > CFG_W'(count_r));
    st.scan_done  = rd_v_r && rd_last_r;
    st.out_free   = !out_valid_r || !out_stall;
    st.last_pos   = (pos_inc == count_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      shard_r <= in_shard_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ovf_r      <= 1'b0;
      taken_r    <= '0;
      scan_act_r <= 1'b0;
      rd_v_r     <= 1'b0;
      pos_r      <= '0;
      have_r     <= 1'b0;
    end else begin
      rd_v_r <= scan_act_r;
      if (cmd.scan_start) begin
        scan_act_r <= 1'b1;
        have_r     <= 1'b0;
      end else if (scan_act_r && (scan_i_inc == count_r)) begin
        scan_act_r <= 1'b0;
      end
      if (rd_v_r && better) begin
        have_r <= 1'b1;
      end
      if (cmd.clear) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        taken_r <= '0;
        pos_r   <= '0;
      end else begin
        if (cmd.store) begin
          if (ram_we) begin
            count_r <= count_r + 1'b1;
          end else begin
            ovf_r <= 1'b1;
          end
        end
        if (cmd.emit) begin
          taken_r[pick_r] <= 1'b1;
          pos_r           <= pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_i_r <= '0;
    end else if (scan_act_r) begin
      scan_i_r <= scan_i_inc;
    end
    rd_idx_r  <= scan_i_r[IDX_W-1:0];
    rd_last_r <= (scan_i_inc == count_r);
    if (rd_v_r && better) begin
      best_r       <= rd_score;
      best_shard_r <= rd_shard;
      pick_r       <= rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_err) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= STATUS_OK;
      out_rank_r   <= RANK_W'(pos_r);
      out_shard_r  <= best_shard_r;
      out_total_r  <= CFG_W'(count_r);
      out_par_r    <= par_min[CFG_W-1:0];
      out_last_r   <= st.last_pos;
    end else if (cmd.emit_err) begin
      out_status_r <= STATUS_ERR;
      out_rank_r   <= '0;
      out_shard_r  <= '0;
      out_total_r  <= CFG_W'(count_r);
      out_par_r    <= '0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_rank          = out_rank_r;
  assign out_ordered_shard = out_shard_r;
  assign out_source_total  = out_total_r;
  assign out_launch_count  = out_par_r;
  assign out_last_result   = out_last_r;

endmodule

/* design/srfp_ctrl.sv */
// Controller: sequences record scoring, the end-of-run check, the ranking
// scans and result emission. Uses srfp_pkg.
module srfp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_last_source,
  output logic                  in_stall,
  input  srfp_pkg::srfp_st_t    st,
  output srfp_pkg::srfp_cmd_t   cmd
);
  import srfp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_CHECK,
    S_SCAN,
    S_EMIT,
    S_ERR
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (st.score_done) begin
          cmd.store = 1'b1;
          state_nxt = last_r ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        if (st.run_err) begin
          state_nxt = S_ERR;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.scan_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.last_pos) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_ERR: begin
        if (st.out_free) begin
          cmd.emit_err = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.start) begin
        last_r <= in_last_source;
      end
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

/* tb/fetch_order_board_pkg.sv */
// Scoreboard for the source rank fetch planner test: record and plan-slot types,
// a copy of the block's registers and a score-ranking predictor. Uses srfp_pkg.
package fetch_order_board_pkg;
  import srfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [REL_W-1:0]   reliab_bp;
    logic [LAT_W-1:0]   latency_ms;
    logic [THR_W-1:0]   xfer_rate;
    logic [SHARD_W-1:0] shard_id;
    logic               last_source;
  } source_rec_t;

  typedef struct packed {
    logic               status;
    logic [RANK_W-1:0]  rank;
    logic [SHARD_W-1:0] ordered_shard;
    logic [CFG_W-1:0]   source_total;
    logic [CFG_W-1:0]   launch_count;
    logic               last_result;
  } plan_slot_t;

  class fetch_order_board;
    logic [SCORE_W-1:0] run_scores[$];
    logic [SHARD_W-1:0] run_shards[$];
    bit                 run_overflow;
    logic [CFG_W-1:0]   need_count;
    logic [CFG_W-1:0]   hedge_count;
    plan_slot_t         expected_slots[$];
    int                 errors;

    function new();
      need_count   = 7'd1;
      hedge_count  = 7'd0;
      run_overflow = 1'b0;
      errors       = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
      if (idx == REG_REQUIRED) begin
        need_count = value;
      end else begin
        hedge_count = value;
      end
    endfunction

    function logic [SCORE_W-1:0] source_score(source_rec_t rec);
      logic [63:0] rel_part;
      logic [63:0] lat_part;
      logic [63:0] thr_part;
      rel_part = (rec.reliab_bp > 16'd10000) ? 64'd10000 : 64'(rec.reliab_bp);
      lat_part = (rec.latency_ms != 0) ? 64'd1000000 / 64'(rec.latency_ms) : 64'd1000000;
      thr_part = 64'(rec.xfer_rate) / 64'd1000000;
      if (thr_part > 64'd100000) thr_part = 64'd100000;
      return SCORE_W'(rel_part * 64'd1000000 + lat_part * 64'd1000 + thr_part);
    endfunction

    function void take_source(source_rec_t rec);
      int          n;
      int          pick;
      bit          have;
      bit          taken[MAX_SOURCES];
      logic [7:0]  par;
      plan_slot_t  slot;
      if (run_scores.size() < MAX_SOURCES) begin
        run_scores.push_back(source_score(rec));
        run_shards.push_back(rec.shard_id);
      end else begin
        run_overflow = 1'b1;
      end
      if (!rec.last_source) return;
      n = run_scores.size();
      if (run_overflow || need_count == 0 || int'(need_count) > n) begin
        slot = '{STATUS_ERR, '0, '0, CFG_W'(n), '0, 1'b1};
        expected_slots.push_back(slot);
      end else begin
        par = {1'b0, need_count} + {1'b0, hedge_count};
        if (int'(par) > n) par = 8'(n);
        foreach (taken[i]) taken[i] = 1'b0;
        for (int pos = 0; pos < n; pos++) begin
          have = 1'b0;
          pick = 0;
          for (int i = 0; i < n; i++) begin
            if (!taken[i] && (!have || run_scores[i] > run_scores[pick])) begin
              have = 1'b1;
              pick = i;
            end
          end
          taken[pick] = 1'b1;
          slot = '{STATUS_OK, RANK_W'(pos), run_shards[pick], CFG_W'(n), CFG_W'(par),
                   (pos + 1 == n)};
          expected_slots.push_back(slot);
        end
      end
      run_scores.delete();
      run_shards.delete();
      run_overflow = 1'b0;
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_slot(plan_slot_t seen);
      plan_slot_t want;
      if (expected_slots.size() == 0) begin
        $display("%0t: unexpected result beat expected none got status %0d shard %0d",
                 $time, seen.status, seen.ordered_shard);
        errors++;
        return;
      end
      want = expected_slots.pop_front();
      compare_field("status", want.status, seen.status);
      compare_field("rank", want.rank, seen.rank);
      compare_field("ordered_shard", want.ordered_shard, seen.ordered_shard);
      compare_field("source_total", want.source_total, seen.source_total);
      compare_field("launch_count", want.launch_count, seen.launch_count);
      compare_field("last_result", want.last_result, seen.last_result);
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction
  endclass

endpackage

/* tb/source_rank_fetch_planner_test.sv */
// Top-level test for source_rank_fetch_planner: drives source records and APB
// register writes, checks every plan beat. Uses srfp_pkg, fetch_order_board_pkg.
module source_rank_fetch_planner_test;
  import srfp_pkg::*;
  import fetch_order_board_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int LONG_HOLD      = 600;
  localparam int SETTLE_CYCLES  = 60;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [REL_W-1:0]   in_reliab_bp = '0;
  logic [LAT_W-1:0]   in_latency_ms = '0;
  logic [THR_W-1:0]   in_xfer_rate = '0;
  logic [SHARD_W-1:0] in_shard_id = '0;
  logic               in_last_source = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_status;
  logic [RANK_W-1:0]  out_rank;
  logic [SHARD_W-1:0] out_ordered_shard;
  logic [CFG_W-1:0]   out_source_total;
  logic [CFG_W-1:0]   out_launch_count;
  logic               out_last_result;

  fetch_order_board board = new();
  bit               long_hold = 1'b0;
  int               send_calm = 0;
  int               quiet_cycles = 0;
  source_rec_t      prev_source = '0;
  plan_slot_t       seen_slot;

  source_rank_fetch_planner dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_slot = '{out_status, out_rank, out_ordered_shard, out_source_total,
                    out_launch_count, out_last_result};
      board.check_slot(seen_slot);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** source_rank_fetch_planner: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_side
    int gap;
    int calm;
    calm = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        gap = LONG_HOLD;
      end else if (calm > 0) begin
        calm--;
        gap = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        calm = $urandom_range(10, 25);
        gap = 0;
      end else begin
        gap = $urandom_range(0, 11);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic send_source(source_rec_t rec);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      send_calm = $urandom_range(10, 25);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 11);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_reliab_bp   <= rec.reliab_bp;
    in_latency_ms  <= rec.latency_ms;
    in_xfer_rate   <= rec.xfer_rate;
    in_shard_id    <= rec.shard_id;
    in_last_source <= rec.last_source;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.take_source(rec);
  endtask

  task automatic send_fixed(logic [REL_W-1:0] rel, logic [LAT_W-1:0] lat,
                            logic [THR_W-1:0] thr, logic [SHARD_W-1:0] shard, logic last);
    source_rec_t rec;
    rec = '{rel, lat, thr, shard, last};
    send_source(rec);
  endtask

  function automatic source_rec_t random_source(logic last);
    source_rec_t rec;
    case ($urandom_range(0, 3))
      0: rec.reliab_bp = REL_W'($urandom_range(0, 10000));
      1: rec.reliab_bp = REL_W'($urandom);
      2: rec.reliab_bp = REL_W'($urandom_range(9990, 10010));
      default: rec.reliab_bp = REL_W'($urandom_range(0, 200));
    endcase
    case ($urandom_range(0, 3))
      0: rec.latency_ms = LAT_W'($urandom_range(0, 3));
      1: rec.latency_ms = LAT_W'($urandom_range(1, 5000));
      2: rec.latency_ms = LAT_W'($urandom);
      default: rec.latency_ms = LAT_W'($urandom_range(999000, 1001000));
    endcase
    case ($urandom_range(0, 3))
      0: rec.xfer_rate = THR_W'({$urandom, $urandom});
      1: rec.xfer_rate = 40'd100000000000 + THR_W'($urandom_range(0, 2000000));
      2: rec.xfer_rate = THR_W'($urandom_range(0, 5000000));
      default: rec.xfer_rate = 40'd1000000 * THR_W'($urandom_range(0, 120000));
    endcase
    if ($urandom_range(0, 7) == 0) begin
      rec.reliab_bp  = prev_source.reliab_bp;
      rec.latency_ms = prev_source.latency_ms;
      rec.xfer_rate  = prev_source.xfer_rate;
    end
    rec.shard_id    = SHARD_W'($urandom);
    rec.last_source = last;
    return rec;
  endfunction

  task automatic send_run(int n);
    source_rec_t rec;
    for (int i = 0; i < n; i++) begin
      rec = random_source(i == n - 1);
      prev_source = rec;
      send_source(rec);
    end
  endtask

  task automatic drain_plan();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] need, logic [CFG_W-1:0] hedge, int items);
    int sent;
    int lo;
    int n;
    write_reg(REG_REQUIRED, need);
    write_reg(REG_HEDGE, hedge);
    sent = 0;
    while (sent < items) begin
      lo = (need == 0) ? 1 : int'(need);
      if (lo <= 6 && $urandom_range(0, 9) < 8) begin
        n = $urandom_range(lo, lo + 4);
      end else begin
        n = $urandom_range(1, 6);
      end
      send_run(n);
      sent += n;
    end
    drain_plan();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_fixed(16'd0, 24'd0, 40'd0, 8'd0, 1'b1);
    send_fixed(16'hFFFF, 24'hFFFFFF, 40'hFF_FFFF_FFFF, 8'hFF, 1'b0);
    send_fixed(16'd10000, 24'd1, 40'd100000999999, 8'd1, 1'b0);
    send_fixed(16'd10001, 24'd1, 40'd100001000000, 8'd2, 1'b0);
    send_fixed(16'd9999, 24'd1000001, 40'd999999, 8'd3, 1'b1);
    send_fixed(16'd5000, 24'd250, 40'd7000000, 8'd10, 1'b0);
    send_fixed(16'd5000, 24'd250, 40'd7000000, 8'd11, 1'b0);
    send_fixed(16'd5000, 24'd250, 40'd7000000, 8'd12, 1'b1);
    send_fixed(16'd1, 24'd1000000, 40'd1000000, 8'h55, 1'b0);
    send_fixed(16'd1, 24'd2, 40'd999999, 8'hAA, 1'b0);
    send_fixed(16'd1, 24'd3, 40'd0, 8'h0F, 1'b1);
    drain_plan();

    long_hold = 1'b1;
    run_phase(7'd3, 7'd2, 6);
    run_phase(7'd1, 7'd0, 4);
    run_phase(7'd5, 7'd127, 6);
    run_phase(7'd0, 7'd4, 2);
    run_phase(7'd127, 7'd127, 2);
    run_phase(7'd2, 7'd64, 4);
    run_phase(7'd64, 7'd0, 2);
    run_phase(7'd4, 7'd1, 4);
    run_phase(7'($urandom_range(1, 6)), 7'($urandom_range(0, 127)), 3);
    run_phase(7'($urandom_range(1, 6)), 7'($urandom_range(0, 127)), 3);

    write_reg(REG_REQUIRED, 7'd32);
    write_reg(REG_HEDGE, 7'd0);
    send_run(MAX_SOURCES);
    drain_plan();
    write_reg(REG_REQUIRED, 7'd1);
    write_reg(REG_HEDGE, 7'd127);
    send_run(MAX_SOURCES + 1);
    drain_plan();

    if (board.errors == 0) begin
      $display("** source_rank_fetch_planner: PASSED **");
    end else begin
      $display("** source_rank_fetch_planner: FAILED **");
    end
    $finish;
  end

endmodule
